[sv/kced_pkg.sv]
// ----------------------------------------------------------------------------
// Key click event detector package
// Shared widths, event bit positions, register indexes and types.
// ----------------------------------------------------------------------------
package kced_pkg;

  // Widths of the item fields and configuration registers.
  localparam int EV_W      = 7;
  localparam int PIN_CNT   = 4;
  localparam int KEY_IDX_W = 2;
  localparam int CD_W      = 16;
  localparam int SP_W      = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  // Event bit positions inside a key's pending event word.
  localparam int EV_HOLD   = 0;
  localparam int EV_DOWN   = 1;
  localparam int EV_UP     = 2;
  localparam int EV_SINGLE = 3;
  localparam int EV_DOUBLE = 4;
  localparam int EV_LONG   = 5;
  localparam int EV_REPEAT = 6;

  // A check mask that asks for hold alone never clears anything.
  localparam logic [EV_W-1:0] EV_HOLD_ONLY = EV_W'(1) << EV_HOLD;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd3;

  // Configuration reset values.
  localparam logic [SP_W-1:0] SAMPLE_PERIOD_RST   = 8'd20;
  localparam logic [CD_W-1:0] DOUBLE_WINDOW_RST   = 16'd200;
  localparam logic [CD_W-1:0] LONG_TIME_RST       = 16'd2000;
  localparam logic [CD_W-1:0] REPEAT_INTERVAL_RST = 16'd100;

  // Timer reload values shared by every key.
  typedef struct packed {
    logic [CD_W-1:0] double_window;
    logic [CD_W-1:0] long_time;
    logic [CD_W-1:0] repeat_interval;
  } kced_cfg_t;

  // Per-key command for one processed item.
  typedef struct packed {
    logic            tick;    // tick item: decrement the countdown
    logic            sample;  // tick item that also samples the pin
    logic            check;   // check item addressed to this key
    logic [EV_W-1:0] mask;    // events asked by the check
  } kced_cmd_t;

endpackage

[sv/key_click_event_detector.sv]
// ----------------------------------------------------------------------------
// Key click event detector
// Push-button classifier for single, double, long and repeated presses.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless out_tready stalls the result
// register, and returns one result for each item, which passes through the input
// register and then the per-key update into the result register. A tick item
// (in_tuser low) counts down every key's timer and, every sample_period ticks,
// samples the pin levels; a check item (in_tuser high) tests and clears the
// asked events of one key. Each result reports the addressed key's pending
// events after the item. Keys at index four and above have no pin and always
// read as released.
module key_click_event_detector
  import kced_pkg::*;
#(
  parameter int NUM_KEYS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input stream.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // pin_levels[3:0], key_index[5:4],
                                           // event_mask[12:6], zero fill
  input  logic                 in_tuser,   // action: 0 tick, 1 check
  // Result stream.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // event_hit[0], key_events[7:1]
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Configuration registers.
  logic [SP_W-1:0] sample_period_r;
  kced_cfg_t       cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r       <= SAMPLE_PERIOD_RST;
      cfg_r.double_window   <= DOUBLE_WINDOW_RST;
      cfg_r.long_time       <= LONG_TIME_RST;
      cfg_r.repeat_interval <= REPEAT_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SAMPLE_PERIOD:   sample_period_r       <= cfg_wdata[SP_W-1:0];
        REG_DOUBLE_WINDOW:   cfg_r.double_window   <= cfg_wdata;
        REG_LONG_TIME:       cfg_r.long_time       <= cfg_wdata;
        REG_REPEAT_INTERVAL: cfg_r.repeat_interval <= cfg_wdata;
        default:             sample_period_r       <= sample_period_r;
      endcase
    end
  end

  // Input register.
  logic                 in_valid_r;
  logic                 action_r;
  logic [PIN_CNT-1:0]   pins_r;
  logic [KEY_IDX_W-1:0] key_r;
  logic [EV_W-1:0]      mask_r;
  logic                 proc_fire;
  logic                 out_valid_r;

  assign proc_fire = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      action_r <= in_tuser;
      pins_r   <= in_tdata[3:0];
      key_r    <= in_tdata[5:4];
      mask_r   <= in_tdata[12:6];
    end
  end

  // Sample divider.
  logic [SP_W-1:0] div_r, div_nxt;
  logic [SP_W:0]   div_inc;
  logic            do_tick;
  logic            do_sample;

  assign do_tick   = proc_fire && !action_r;
  assign div_inc   = {1'b0, div_r} + (SP_W+1)'(1);
  assign do_sample = (div_inc >= {1'b0, sample_period_r});

  always_comb begin
    div_nxt = div_r;
    if (do_tick) begin
      div_nxt = do_sample ? '0 : div_inc[SP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= '0;
    end else begin
      div_r <= div_nxt;
    end
  end

  // Per-key state.
  logic [EV_W-1:0] ev_cur [NUM_KEYS];
  logic [EV_W-1:0] ev_nxt [NUM_KEYS];

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    kced_cmd_t cmd;
    logic      pressed;

    if (k < PIN_CNT) begin : g_pin
      assign pressed = ~pins_r[k];
    end else begin : g_nopin
      assign pressed = 1'b0;
    end

    assign cmd.tick   = do_tick;
    assign cmd.sample = do_sample;
    assign cmd.check  = proc_fire && action_r && (int'(key_r) == k);
    assign cmd.mask   = mask_r;

    kced_key u_key (
      .clk     (clk),
      .rst_n   (rst_n),
      .cfg     (cfg_r),
      .cmd     (cmd),
      .pressed (pressed),
      .ev_cur  (ev_cur[k]),
      .ev_nxt  (ev_nxt[k])
    );
  end

  // Select the addressed key; an index past the last key reads as zero.
  logic [EV_W-1:0] sel_cur;
  logic [EV_W-1:0] sel_nxt;
  logic            hit;

  always_comb begin
    sel_cur = '0;
    sel_nxt = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (int'(key_r) == k) begin
        sel_cur = ev_cur[k];
        sel_nxt = ev_nxt[k];
      end
    end
  end

  assign hit = action_r && ((sel_cur & mask_r) != '0);

  // Result register.
  logic            out_hit_r;
  logic [EV_W-1:0] out_events_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      out_hit_r    <= hit;
      out_events_r <= sel_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_events_r, out_hit_r};

endmodule

[sv/kced_key.sv]
// ----------------------------------------------------------------------------
// Key click event detector, single key
// Holds one key's countdown, click state and pending events, and updates them
// for each processed tick or check item.
// ----------------------------------------------------------------------------
module kced_key
  import kced_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  kced_cfg_t       cfg,
  input  kced_cmd_t       cmd,
  input  logic            pressed,
  output logic [EV_W-1:0] ev_cur,
  output logic [EV_W-1:0] ev_nxt
);

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_PRESSED   = 3'd1,
    MODE_DBL_WAIT  = 3'd2,
    MODE_AFTER_DBL = 3'd3,
    MODE_REPEAT    = 3'd4
  } mode_t;

  mode_t           mode_r, mode_nxt;
  logic            last_r, last_nxt;
  logic [CD_W-1:0] cd_r, cd_nxt;
  logic [CD_W-1:0] cd_dec;
  logic [EV_W-1:0] ev_r;

  // Countdown after this tick's decrement; it saturates at zero.
  assign cd_dec = (cd_r != '0) ? (cd_r - CD_W'(1)) : cd_r;

  // Next state for one item.
  always_comb begin
    mode_nxt = mode_r;
    last_nxt = last_r;
    cd_nxt   = cd_r;
    ev_nxt   = ev_r;
    if (cmd.tick) begin
      cd_nxt = cd_dec;
      if (cmd.sample) begin
        last_nxt        = pressed;
        ev_nxt[EV_HOLD] = pressed;
        if (pressed && !last_r) begin
          ev_nxt[EV_DOWN] = 1'b1;
        end
        if (!pressed && last_r) begin
          ev_nxt[EV_UP] = 1'b1;
        end
        case (mode_r)
          MODE_IDLE: begin
            if (pressed) begin
              cd_nxt   = cfg.long_time;
              mode_nxt = MODE_PRESSED;
            end
          end
          MODE_PRESSED: begin
            if (!pressed) begin
              cd_nxt   = cfg.double_window;
              mode_nxt = MODE_DBL_WAIT;
            end else if (cd_dec == '0) begin
              cd_nxt          = cfg.repeat_interval;
              ev_nxt[EV_LONG] = 1'b1;
              mode_nxt        = MODE_REPEAT;
            end
          end
          MODE_DBL_WAIT: begin
            if (pressed) begin
              ev_nxt[EV_DOUBLE] = 1'b1;
              mode_nxt          = MODE_AFTER_DBL;
            end else if (cd_dec == '0) begin
              ev_nxt[EV_SINGLE] = 1'b1;
              mode_nxt          = MODE_IDLE;
            end
          end
          MODE_AFTER_DBL: begin
            if (!pressed) begin
              mode_nxt = MODE_IDLE;
            end
          end
          MODE_REPEAT: begin
            if (!pressed) begin
              mode_nxt = MODE_IDLE;
            end else if (cd_dec == '0) begin
              cd_nxt            = cfg.repeat_interval;
              ev_nxt[EV_REPEAT] = 1'b1;
            end
          end
          default: begin
            mode_nxt = mode_r;
          end
        endcase
      end
    end else if (cmd.check) begin
      // A hit clears the asked bits, except when hold alone is asked.
      if (((ev_r & cmd.mask) != '0) && (cmd.mask != EV_HOLD_ONLY)) begin
        ev_nxt = ev_r & ~cmd.mask;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      last_r <= 1'b0;
      cd_r   <= '0;
      ev_r   <= '0;
    end else begin
      mode_r <= mode_nxt;
      last_r <= last_nxt;
      cd_r   <= cd_nxt;
      ev_r   <= ev_nxt;
    end
  end

  assign ev_cur = ev_r;

endmodule

[sim/key_click_event_detector_checker.sv]
// ----------------------------------------------------------------------------
// Key click event detector checker
// Watches the input, result and configuration ports of the click detector,
// predicts each result from its own copy of the key timers and click states,
// and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module key_click_event_detector_checker
  import kced_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [15:0]          in_tdata,   // pin_levels[3:0], key_index[5:4],
                                           // event_mask[12:6], zero fill
  input  logic                 in_tuser,   // action: 0 tick, 1 check
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [7:0]           out_tdata,  // event_hit[0], key_events[7:1]
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending
);

  localparam int KEYS       = 4;
  localparam int SHOW_LIMIT = 10;

  typedef enum logic [2:0] {
    CS_IDLE       = 3'd0,
    CS_PRESSED    = 3'd1,
    CS_DBL_WAIT   = 3'd2,
    CS_AFTER_DBL  = 3'd3,
    CS_REPEATING  = 3'd4
  } click_state_t;

  typedef struct packed {
    logic            hit;
    logic [EV_W-1:0] events;
  } key_report_t;

  // Configuration copy.
  logic [SP_W-1:0] period;
  logic [CD_W-1:0] dbl_win;
  logic [CD_W-1:0] long_ticks;
  logic [CD_W-1:0] rpt_ticks;

  // Per-key predicted state.
  logic [SP_W-1:0] divider;
  logic            was_pressed [KEYS];
  click_state_t    click_state [KEYS];
  logic [CD_W-1:0] key_timer   [KEYS];
  logic [EV_W-1:0] key_ev      [KEYS];

  key_report_t expected_reports[$];

  // One sample of one key: hold and edge flags, then the click state step.
  function automatic void sample_key(int k, logic [PIN_CNT-1:0] levels);
    logic            now;
    logic            was;
    logic [EV_W-1:0] ev;
    now = ~levels[k];
    was = was_pressed[k];
    ev  = key_ev[k];
    was_pressed[k] = now;
    ev[EV_HOLD] = now;
    if (now && !was) ev[EV_DOWN] = 1'b1;
    if (!now && was) ev[EV_UP] = 1'b1;
    case (click_state[k])
      CS_IDLE: begin
        if (now) begin
          key_timer[k]   = long_ticks;
          click_state[k] = CS_PRESSED;
        end
      end
      CS_PRESSED: begin
        if (!now) begin
          key_timer[k]   = dbl_win;
          click_state[k] = CS_DBL_WAIT;
        end else if (key_timer[k] == '0) begin
          key_timer[k]   = rpt_ticks;
          ev[EV_LONG]    = 1'b1;
          click_state[k] = CS_REPEATING;
        end
      end
      CS_DBL_WAIT: begin
        if (now) begin
          ev[EV_DOUBLE]  = 1'b1;
          click_state[k] = CS_AFTER_DBL;
        end else if (key_timer[k] == '0) begin
          ev[EV_SINGLE]  = 1'b1;
          click_state[k] = CS_IDLE;
        end
      end
      CS_AFTER_DBL: begin
        if (!now) click_state[k] = CS_IDLE;
      end
      CS_REPEATING: begin
        if (!now) begin
          click_state[k] = CS_IDLE;
        end else if (key_timer[k] == '0) begin
          key_timer[k]  = rpt_ticks;
          ev[EV_REPEAT] = 1'b1;
        end
      end
      default: ;
    endcase
    key_ev[k] = ev;
  endfunction

  // Apply one input item to the predicted state and return its report.
  function automatic key_report_t predict_report(logic is_check, logic [PIN_CNT-1:0] levels,
                                                 logic [KEY_IDX_W-1:0] key,
                                                 logic [EV_W-1:0] mask);
    key_report_t rep;
    rep.hit = 1'b0;
    if (!is_check) begin
      for (int k = 0; k < KEYS; k++)
        if (key_timer[k] != '0) key_timer[k] = key_timer[k] - 1'b1;
      if ({1'b0, divider} + 9'd1 >= {1'b0, period}) begin
        divider = '0;
        for (int k = 0; k < KEYS; k++) sample_key(k, levels);
      end else begin
        divider = divider + 1'b1;
      end
    end else if ((key_ev[key] & mask) != '0) begin
      rep.hit = 1'b1;
      // Asking for hold alone reads the flag without clearing it.
      if (mask != EV_HOLD_ONLY) key_ev[key] = key_ev[key] & ~mask;
    end
    rep.events = key_ev[key];
    return rep;
  endfunction

  function automatic void count_failure(string what, key_report_t got, key_report_t want);
    fail_count++;
    if (fail_count <= SHOW_LIMIT)
      $display("[%0t] %s: got hit=%0b events=%07b, expected hit=%0b events=%07b",
               $realtime, what, got.hit, got.events, want.hit, want.events);
  endfunction

  // Track configuration writes, predict on input transfers, compare on result transfers.
  always @(posedge clk) begin : watch
    key_report_t got;
    key_report_t want;
    if (!rst_n) begin
      period     = SAMPLE_PERIOD_RST;
      dbl_win    = DOUBLE_WINDOW_RST;
      long_ticks = LONG_TIME_RST;
      rpt_ticks  = REPEAT_INTERVAL_RST;
      divider    = '0;
      for (int k = 0; k < KEYS; k++) begin
        was_pressed[k] = 1'b0;
        click_state[k] = CS_IDLE;
        key_timer[k]   = '0;
        key_ev[k]      = '0;
      end
      expected_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_SAMPLE_PERIOD:   period     = cfg_wdata[SP_W-1:0];
          REG_DOUBLE_WINDOW:   dbl_win    = cfg_wdata[CD_W-1:0];
          REG_LONG_TIME:       long_ticks = cfg_wdata[CD_W-1:0];
          REG_REPEAT_INTERVAL: rpt_ticks  = cfg_wdata[CD_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.hit    = out_tdata[0];
        got.events = out_tdata[7:1];
        if (expected_reports.size() == 0) begin
          want = '0;
          count_failure("result transfer with nothing expected", got, want);
        end else begin
          want = expected_reports.pop_front();
          if (got.hit !== want.hit || got.events !== want.events)
            count_failure("result mismatch", got, want);
        end
      end
      if (in_tvalid && in_tready)
        expected_reports.push_back(predict_report(in_tuser, in_tdata[3:0], in_tdata[5:4],
                                                  in_tdata[12:6]));
    end
    pending = expected_reports.size();
  end

endmodule

[sim/key_click_event_detector_test.sv]
// ----------------------------------------------------------------------------
// Key click event detector testbench
// Drives directed and random tick and check items through several timer
// settings, with random sender gaps and receiver stalls, and lets a checker
// module compare every result against its own prediction.
// ----------------------------------------------------------------------------
module key_click_event_detector_test
  import kced_pkg::*;
();

  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_CHECK  = 1'b1;
  localparam int   IDLE_LIMIT = 2000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [15:0]          in_tdata;
  logic                 in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0]     cfg_wdata;

  int fail_count;
  int pending;

  // Sender and receiver pacing.
  int          burst_left  = 0;
  int          stall_left  = 0;
  int          stall_mode  = 0;
  int          idle_cycles = 0;

  // Simulated key presses for well-formed random ticks.
  logic [PIN_CNT-1:0] level_now = '1;
  int unsigned        run_left [PIN_CNT];
  int unsigned        run_span = 8;

  key_click_event_detector DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  key_click_event_detector_checker event_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: each time stall_left runs out, pick always ready, random stalls, or one in four.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = 64;
    end
    stall_left--;
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= (stall_left % 4) == 0;
    endcase
  end

  // Watchdog: end the run when no transfer or write happens for too long.
  always @(posedge clk) begin
    if (rst_n && !(in_tvalid && in_tready) && !(out_tvalid && out_tready) && !cfg_we)
      idle_cycles++;
    else
      idle_cycles = 0;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** key_click_event_detector: FAILED **");
      $finish;
    end
  end

  function automatic logic [EV_W-1:0] ev_bit(int pos);
    return EV_W'(1) << pos;
  endfunction

  // Send one item; a new burst begins with a random gap.
  task automatic push_item(input logic act, input logic [PIN_CNT-1:0] pins,
                           input logic [KEY_IDX_W-1:0] key, input logic [EV_W-1:0] mask);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {3'b000, mask, key, pins};
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic hold_off();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
  endtask

  task automatic set_config(input logic [SP_W-1:0] sp, input logic [CD_W-1:0] dw,
                            input logic [CD_W-1:0] lt, input logic [CD_W-1:0] ri);
    hold_off();
    write_reg(REG_SAMPLE_PERIOD, CFG_W'(sp));
    write_reg(REG_DOUBLE_WINDOW, dw);
    write_reg(REG_LONG_TIME, lt);
    write_reg(REG_REPEAT_INTERVAL, ri);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // A random item: mostly ticks that follow held and released keys, some checks.
  task automatic random_item();
    logic [PIN_CNT-1:0]   pins;
    logic [KEY_IDX_W-1:0] key;
    logic [EV_W-1:0]      mask;
    key = KEY_IDX_W'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 5))
        0:       mask = '0;
        1:       mask = EV_HOLD_ONLY;
        2:       mask = ev_bit($urandom_range(0, EV_W - 1));
        default: mask = EV_W'($urandom_range(0, 127));
      endcase
      push_item(ACT_CHECK, PIN_CNT'($urandom_range(0, 15)), key, mask);
    end else begin
      // Each key toggles after a run of ticks, mostly short, sometimes long.
      for (int k = 0; k < PIN_CNT; k++) begin
        if (run_left[k] == 0) begin
          level_now[k] = ~level_now[k];
          run_left[k]  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, run_span)
                                                     : $urandom_range(1, run_span / 4 + 1);
        end else begin
          run_left[k]--;
        end
      end
      pins = ($urandom_range(0, 9) == 0) ? PIN_CNT'($urandom_range(0, 15)) : level_now;
      push_item(ACT_TICK, pins, key, EV_W'($urandom_range(0, 127)));
    end
  endtask

  task automatic run_phase(input logic [SP_W-1:0] sp, input logic [CD_W-1:0] dw,
                           input logic [CD_W-1:0] lt, input logic [CD_W-1:0] ri,
                           input int count, input int unsigned span);
    set_config(sp, dw, lt, ri);
    run_span = span;
    repeat (count) random_item();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = ACT_TICK;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = REG_SAMPLE_PERIOD;
    cfg_wdata  = '0;
    for (int k = 0; k < PIN_CNT; k++) run_left[k] = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Checks on the fresh block: nothing pending, and an empty mask.
    push_item(ACT_CHECK, 4'hF, 2'd0, 7'h7F);
    push_item(ACT_CHECK, 4'h0, 2'd3, 7'h00);

    // Sample on every tick with short timers.
    set_config(8'd0, 16'd3, 16'd4, 16'd2);
    push_item(ACT_TICK, 4'h0, 2'd0, 7'h00);
    // Hold alone reports without clearing.
    push_item(ACT_CHECK, 4'hF, 2'd0, EV_HOLD_ONLY);
    push_item(ACT_CHECK, 4'hF, 2'd1, 7'h00);
    // All keys held through long press into repeat.
    repeat (6) push_item(ACT_TICK, 4'h0, 2'd2, 7'h00);
    push_item(ACT_CHECK, 4'hF, 2'd2, 7'h7F);
    push_item(ACT_TICK, 4'hF, 2'd3, 7'h7F);
    push_item(ACT_CHECK, 4'hF, 2'd3, ev_bit(EV_UP));
    // Key 0 single click: press, release, let the window run out.
    push_item(ACT_TICK, 4'hE, 2'd0, 7'h00);
    repeat (4) push_item(ACT_TICK, 4'hF, 2'd0, 7'h00);
    // Key 1 double click.
    push_item(ACT_TICK, 4'hD, 2'd1, 7'h00);
    push_item(ACT_TICK, 4'hF, 2'd1, 7'h00);
    push_item(ACT_TICK, 4'hD, 2'd1, 7'h00);
    push_item(ACT_TICK, 4'hF, 2'd1, 7'h00);
    push_item(ACT_CHECK, 4'hF, 2'd0, ev_bit(EV_SINGLE));
    push_item(ACT_CHECK, 4'h0, 2'd1, ev_bit(EV_DOUBLE) | ev_bit(EV_DOWN));

    // Random phases over several timer settings, extremes included.
    run_phase(SAMPLE_PERIOD_RST, DOUBLE_WINDOW_RST, LONG_TIME_RST, REPEAT_INTERVAL_RST,
              80, 60);
    run_phase(8'd1, 16'd0, 16'd0, 16'd0, 100, 8);
    run_phase(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 70, 100);
    run_phase(8'd2, CD_W'($urandom_range(2, 8)), CD_W'($urandom_range(3, 12)),
              CD_W'($urandom_range(1, 4)), 200, 30);
    run_phase(8'd0, CD_W'($urandom_range(1, 6)), CD_W'($urandom_range(2, 8)),
              CD_W'($urandom_range(0, 3)), 150, 20);

    hold_off();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("** key_click_event_detector: PASSED **");
    else
      $display("** key_click_event_detector: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
sv/kced_pkg.sv
sv/kced_key.sv
sv/key_click_event_detector.sv
sim/key_click_event_detector_checker.sv
sim/key_click_event_detector_test.sv
